### rtl/core/grt_pkg.sv
// shared types, constants and divider step function for the grid id rescale block
`default_nettype none
package grt_pkg;
   localparam int DIMS = 3;
   localparam int DIM_MAX = 3;
   localparam int SIDE_W = 11;
   localparam int ID_W = 30;
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam int DIV_STEP = 3;
   localparam int DIV_STAGES = (ID_W + DIV_STEP - 1) / DIV_STEP;
   localparam int M_W = 2 * SIDE_W;
   localparam int PROD_W = 3 * SIDE_W;
   localparam int ENC_W = PROD_W + 1 + SIDE_W;
   localparam int RES_W = ENC_W + 1;
   localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};
   localparam logic CMD_BWD = 1'b1;

   typedef logic [DIM_MAX-1:0][SIDE_W-1:0] sides_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_ID_RANGE   = 2'd1,
      ST_RES_RANGE  = 2'd2,
      ST_ZERO_RATIO = 2'd3
   } status_type;

   typedef enum logic [ADDR_W-1:0] {
      REG_IN_X  = 3'd0,
      REG_IN_Y  = 3'd1,
      REG_IN_Z  = 3'd2,
      REG_OUT_X = 3'd3,
      REG_OUT_Y = 3'd4,
      REG_OUT_Z = 3'd5
   } reg_type;

   typedef struct packed {
      logic              valid;
      logic              bwd;
      logic [ID_W-1:0]   id;
      logic [ID_W-1:0]   quo;
      sides_type         coord;
      sides_type         ratio;
      logic              zr;
   } side_type;

   typedef struct packed {
      logic [SIDE_W-1:0] rem;
      logic [ID_W-1:0]   dvd;
      logic [ID_W-1:0]   quo;
      logic [SIDE_W-1:0] dsr;
   } div_type;

   function automatic div_type div_steps(input div_type s);
      div_type r;
      logic [SIDE_W:0] t;
      r = s;
      for (int i = 0; i < DIV_STEP; i++) begin
         t = {r.rem, r.dvd[ID_W-1]};
         if (t >= {1'b0, r.dsr}) begin
            t = t - {1'b0, r.dsr};
            r.quo = {r.quo[ID_W-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[ID_W-2:0], 1'b0};
         end
         r.rem = t[SIDE_W-1:0];
         r.dvd = {r.dvd[ID_W-2:0], 1'b0};
      end
      return r;
   endfunction
endpackage
`default_nettype wire

### rtl/core/grt_div.sv
// pipelined restoring divider, id-wide dividend by side-wide divisor
`default_nettype none
module grt_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [grt_pkg::ID_W-1:0]    dividend,
   input  logic [grt_pkg::SIDE_W-1:0]  divisor,
   output logic [grt_pkg::ID_W-1:0]    quotient,
   output logic [grt_pkg::SIDE_W-1:0]  remainder
);
   import grt_pkg::*;

   div_type st_ff [DIV_STAGES];
   div_type st_in [DIV_STAGES];

   always_comb begin
      div_type first;
      first.rem = '0;
      first.dvd = dividend;
      first.quo = '0;
      first.dsr = divisor;
      st_in[0] = div_steps(first);
      for (int k = 1; k < DIV_STAGES; k++) begin
         st_in[k] = div_steps(st_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign quotient  = st_ff[DIV_STAGES-1].quo;
   assign remainder = st_ff[DIV_STAGES-1].rem;
endmodule
`default_nettype wire

### rtl/core/grt_delay.sv
// item sideband delay line matching the divider latency
`default_nettype none
module grt_delay (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  grt_pkg::side_type   d,
   output grt_pkg::side_type   q
);
   import grt_pkg::*;

   side_type dl_ff [DIV_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            dl_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         dl_ff[0] <= d;
         for (int k = 1; k < DIV_STAGES; k++) begin
            dl_ff[k] <= dl_ff[k-1];
         end
      end
   end

   assign q = dl_ff[DIV_STAGES-1];
endmodule
`default_nettype wire

### rtl/core/grt_encode.sv
// coordinate scaling, re-encoding and range checks, ending in the output register
`default_nettype none
module grt_encode (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  grt_pkg::side_type           d,
   input  grt_pkg::sides_type          fwd_quo,
   input  grt_pkg::sides_type          in_side,
   input  grt_pkg::sides_type          out_side,
   output logic                        valid,
   output logic [grt_pkg::ID_W-1:0]    mapped_id,
   output grt_pkg::status_type         status
);
   import grt_pkg::*;

   // stage 1: scaled coordinates
   logic                          v1_ff, bwd1_ff, zr1_ff;
   logic [ID_W-1:0]               id1_ff;
   logic [DIM_MAX-1:0][M_W-1:0]   m1_ff, m1_in;
   // stage 2: partial encode and partial grid sizes
   logic                          v2_ff, zr2_ff;
   logic [ID_W-1:0]               id2_ff;
   logic [M_W-1:0]                a2_ff, b2_ff;
   logic [PROD_W-1:0]             p2_ff;
   logic [M_W-1:0]                src2_ff, dst2_ff;
   logic [SIDE_W-1:0]             s2z_ff, d2z_ff, d2x_ff;
   // stage 3
   logic                          v3_ff, zr3_ff;
   logic [ID_W-1:0]               id3_ff;
   logic [M_W-1:0]                a3_ff;
   logic [ENC_W-1:0]              t3_ff;
   logic [PROD_W-1:0]             src3_ff, dst3_ff;
   // output
   logic                          v4_ff;
   logic [ID_W-1:0]               id4_ff, id4_in;
   status_type                    st4_ff, st4_in;
   sides_type                     src_s, dst_s;
   logic [RES_W-1:0]              res;

   always_comb begin
      for (int k = 0; k < DIM_MAX; k++) begin
         if (d.bwd == CMD_BWD) begin
            m1_in[k] = M_W'(d.coord[k]) * M_W'(d.ratio[k]) + M_W'(d.ratio[k] >> 1);
         end else begin
            m1_in[k] = M_W'(fwd_quo[k]);
         end
      end
   end

   assign src_s = (bwd1_ff == CMD_BWD) ? out_side : in_side;
   assign dst_s = (bwd1_ff == CMD_BWD) ? in_side : out_side;

   assign res = RES_W'(t3_ff) + RES_W'(a3_ff);

   always_comb begin
      id4_in = '0;
      if (zr3_ff) begin
         st4_in = ST_ZERO_RATIO;
      end else if (PROD_W'(id3_ff) >= src3_ff) begin
         st4_in = ST_ID_RANGE;
      end else if (res >= RES_W'(dst3_ff) || res > RES_W'(ID_MAX)) begin
         st4_in = ST_RES_RANGE;
      end else begin
         st4_in = ST_OK;
         id4_in = res[ID_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= d.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bwd1_ff <= d.bwd;
         zr1_ff  <= d.zr;
         id1_ff  <= d.id;
         m1_ff   <= m1_in;

         zr2_ff  <= zr1_ff;
         id2_ff  <= id1_ff;
         a2_ff   <= m1_ff[0];
         b2_ff   <= m1_ff[1];
         p2_ff   <= PROD_W'(m1_ff[2]) * PROD_W'(dst_s[1]);
         src2_ff <= M_W'(src_s[0]) * M_W'(src_s[1]);
         dst2_ff <= M_W'(dst_s[0]) * M_W'(dst_s[1]);
         s2z_ff  <= src_s[2];
         d2z_ff  <= dst_s[2];
         d2x_ff  <= dst_s[0];

         zr3_ff  <= zr2_ff;
         id3_ff  <= id2_ff;
         a3_ff   <= a2_ff;
         t3_ff   <= (ENC_W'(p2_ff) + ENC_W'(b2_ff)) * ENC_W'(d2x_ff);
         src3_ff <= PROD_W'(src2_ff) * PROD_W'(s2z_ff);
         dst3_ff <= PROD_W'(dst2_ff) * PROD_W'(d2z_ff);

         id4_ff  <= id4_in;
         st4_ff  <= st4_in;
      end
   end

   assign valid     = v4_ff;
   assign mapped_id = id4_ff;
   assign status    = st4_ff;
endmodule
`default_nettype wire

### rtl/core/grid_id_rescale_transform.sv
// top level: maps linear cell ids between a fine and a coarse grid
//
//  channel  direction  fields
//  req      in         tdata: cell_id[29:0]; tuser: cmd
//  rsp      out        tdata: mapped_id[29:0]; tuser: status[1:0]
//  csr      in         csr_addr: register index; csr_wdata: side length
//
// one item per cycle while results are taken; three 30-bit divider segments in series,
// of 10 stages each (3 quotient bits per stage) plus 4 encode stages
// reset sets all sides to 1 and empties the pipeline
// a result not taken holds the whole pipeline; a one-item input skid keeps
// req_tready registered
`default_nettype none
module grid_id_rescale_transform (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [grt_pkg::DATA_W-1:0]    req_tdata,   // cell_id
   input  logic                          req_tuser,   // cmd
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [grt_pkg::DATA_W-1:0]    rsp_tdata,   // mapped_id
   output logic [1:0]                    rsp_tuser,   // status
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [grt_pkg::ADDR_W-1:0]    csr_addr,
   input  logic [grt_pkg::SIDE_W-1:0]    csr_wdata
);
   import grt_pkg::*;

   sides_type         in_side_ff, in_side_in, out_side_ff, out_side_in;
   sides_type         eff_in, eff_out;
   logic              adv;
   logic              skid_valid_ff, skid_valid_in;
   logic              skid_bwd_ff;
   logic [ID_W-1:0]   skid_id_ff;
   side_type          entry, del_a, side_b, del_b, side_c, del_c;
   logic [ID_W-1:0]   quo_a, quo_b;
   logic [SIDE_W-1:0] rem_a, rem_b;
   logic [DIM_MAX-1:0][ID_W-1:0]   ratio_quo, fwd_quo_w;
   logic [DIM_MAX-1:0][SIDE_W-1:0] ratio_rem, fwd_rem;
   sides_type         fwd_quo;
   logic              zr_b;
   logic              enc_valid;
   logic [ID_W-1:0]   enc_id;
   status_type        enc_status;

   assign csr_ready = 1'b1;

   always_comb begin
      in_side_in  = in_side_ff;
      out_side_in = out_side_ff;
      if (csr_valid) begin
         case (reg_type'(csr_addr))
            REG_IN_X:  in_side_in[0]  = csr_wdata;
            REG_IN_Y:  in_side_in[1]  = csr_wdata;
            REG_IN_Z:  in_side_in[2]  = csr_wdata;
            REG_OUT_X: out_side_in[0] = csr_wdata;
            REG_OUT_Y: out_side_in[1] = csr_wdata;
            REG_OUT_Z: out_side_in[2] = csr_wdata;
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIM_MAX; k++) begin
            in_side_ff[k]  <= SIDE_W'(1);
            out_side_ff[k] <= SIDE_W'(1);
         end
      end else begin
         in_side_ff  <= in_side_in;
         out_side_ff <= out_side_in;
      end
   end

   always_comb begin
      for (int k = 0; k < DIM_MAX; k++) begin
         eff_in[k]  = (k < DIMS) ? in_side_ff[k]  : SIDE_W'(1);
         eff_out[k] = (k < DIMS) ? out_side_ff[k] : SIDE_W'(1);
      end
   end

   // input skid
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = !skid_valid_ff;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (adv) begin
         skid_valid_in = 1'b0;
      end else if (req_tvalid && req_tready) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!adv && req_tvalid && req_tready) begin
         skid_bwd_ff <= req_tuser;
         skid_id_ff  <= req_tdata[ID_W-1:0];
      end
   end

   always_comb begin
      entry       = '0;
      entry.valid = skid_valid_ff || req_tvalid;
      entry.bwd   = skid_valid_ff ? skid_bwd_ff : req_tuser;
      entry.id    = skid_valid_ff ? skid_id_ff : req_tdata[ID_W-1:0];
   end

   // segment a: split off coordinate 0, compute ratios
   grt_div u_div_a (
      .clock     (clock),
      .en        (adv),
      .dividend  (entry.id),
      .divisor   ((entry.bwd == CMD_BWD) ? eff_out[0] : eff_in[0]),
      .quotient  (quo_a),
      .remainder (rem_a)
   );

   for (genvar g = 0; g < DIM_MAX; g++) begin : g_ratio
      grt_div u_div_r (
         .clock     (clock),
         .en        (adv),
         .dividend  (ID_W'(eff_in[g])),
         .divisor   (eff_out[g]),
         .quotient  (ratio_quo[g]),
         .remainder (ratio_rem[g])
      );
   end

   grt_delay u_del_a (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .d     (entry),
      .q     (del_a)
   );

   always_comb begin
      zr_b = 1'b0;
      for (int k = 0; k < DIM_MAX; k++) begin
         if (eff_out[k] == '0 || ratio_quo[k] == '0) begin
            zr_b = 1'b1;
         end
      end
      side_b          = del_a;
      side_b.quo      = quo_a;
      side_b.coord[0] = rem_a;
      for (int k = 0; k < DIM_MAX; k++) begin
         side_b.ratio[k] = ratio_quo[k][SIDE_W-1:0] | (ratio_rem[k] & '0);
      end
      side_b.zr = zr_b;
   end

   // segment b: coordinates 1 and 2
   grt_div u_div_b (
      .clock     (clock),
      .en        (adv),
      .dividend  (side_b.quo),
      .divisor   ((side_b.bwd == CMD_BWD) ? eff_out[1] : eff_in[1]),
      .quotient  (quo_b),
      .remainder (rem_b)
   );

   grt_delay u_del_b (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .d     (side_b),
      .q     (del_b)
   );

   always_comb begin
      side_c          = del_b;
      side_c.coord[1] = rem_b;
      side_c.coord[2] = quo_b[SIDE_W-1:0];
   end

   // segment c: forward downscale per coordinate
   for (genvar g = 0; g < DIM_MAX; g++) begin : g_fwd
      grt_div u_div_c (
         .clock     (clock),
         .en        (adv),
         .dividend  (ID_W'(side_c.coord[g])),
         .divisor   (side_c.ratio[g]),
         .quotient  (fwd_quo_w[g]),
         .remainder (fwd_rem[g])
      );
      assign fwd_quo[g] = fwd_quo_w[g][SIDE_W-1:0] | (fwd_rem[g] & '0);
   end

   grt_delay u_del_c (
      .clock (clock),
      .reset (reset),
      .en    (adv),
      .d     (side_c),
      .q     (del_c)
   );

   grt_encode u_encode (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .d         (del_c),
      .fwd_quo   (fwd_quo),
      .in_side   (eff_in),
      .out_side  (eff_out),
      .valid     (enc_valid),
      .mapped_id (enc_id),
      .status    (enc_status)
   );

   assign rsp_tvalid = enc_valid;
   assign rsp_tdata  = DATA_W'(enc_id);
   assign rsp_tuser  = enc_status;

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && adv |=> !skid_valid_ff)
      else $error("skid item not drained on advance");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == '0)
      else $error("error result carries nonzero id");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && !skid_valid_ff)
      else $error("pipeline not empty after reset");
endmodule
`default_nettype wire

### tb/tb.sv
// testbench for the grid id rescale block: directed table and random ids checked by a predictor
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import grt_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [DATA_W-1:0] req_tdata = '0;   // cell_id
   logic req_tuser = 1'b0;              // cmd
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;        // mapped_id
   logic [1:0] rsp_tuser;               // status
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [ADDR_W-1:0] csr_addr = '0;
   logic [SIDE_W-1:0] csr_wdata = '0;

   grid_id_rescale_transform i_dut (.*);

   always #5 clock = ~clock;

   typedef struct {
      logic [ID_W-1:0] id;
      status_type st;
   } map_type;

   typedef struct {
      logic bwd;
      logic [ID_W-1:0] id;
      logic fixed;
      logic [ID_W-1:0] exp_id;
      status_type exp_st;
   } row_type;

   logic [SIDE_W-1:0] in_sides [3];
   logic [SIDE_W-1:0] out_sides [3];
   map_type pending_maps [$];
   int errors = 0;
   int cycles = 0;
   int send_idle = 0;
   int recv_stall = 0;

   function automatic map_type predict_map(logic bwd, logic [ID_W-1:0] id);
      map_type m;
      longint unsigned ratio [3];
      longint unsigned src_sz, dst_sz, sp, dp, res, c, v, ss, ds;
      m.id = '0;
      for (int d = 0; d < 3; d++) begin
         if (out_sides[d] == 0 || in_sides[d] / out_sides[d] == 0) begin
            m.st = ST_ZERO_RATIO;
            return m;
         end
         ratio[d] = in_sides[d] / out_sides[d];
      end
      src_sz = 1;
      dst_sz = 1;
      for (int d = 0; d < 3; d++) begin
         src_sz *= bwd ? out_sides[d] : in_sides[d];
         dst_sz *= bwd ? in_sides[d] : out_sides[d];
      end
      if (id >= src_sz) begin
         m.st = ST_ID_RANGE;
         return m;
      end
      sp = 1;
      dp = 1;
      res = 0;
      for (int d = 0; d < 3; d++) begin
         ss = bwd ? out_sides[d] : in_sides[d];
         ds = bwd ? in_sides[d] : out_sides[d];
         c = (id / sp) % ss;
         v = bwd ? c * ratio[d] + ratio[d] / 2 : c / ratio[d];
         res += v * dp;
         sp *= ss;
         dp *= ds;
      end
      if (res >= dst_sz || res > ID_MAX) begin
         m.st = ST_RES_RANGE;
         return m;
      end
      m.id = res[ID_W-1:0];
      m.st = ST_OK;
      return m;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_stall);
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_maps.size() == 0) begin
            $display("%0t: unexpected item id %0h status %0d", $realtime, rsp_tdata[ID_W-1:0],
               rsp_tuser);
            errors <= errors + 1;
         end else begin
            if (rsp_tdata !== {{(DATA_W-ID_W){1'b0}}, pending_maps[0].id}
               || rsp_tuser !== pending_maps[0].st) begin
               $display("%0t: mismatch expected id %0h status %0d, actual id %0h status %0d",
                  $realtime, pending_maps[0].id, pending_maps[0].st, rsp_tdata, rsp_tuser);
               errors <= errors + 1;
            end
            void'(pending_maps.pop_front());
         end
      end
   end

   task automatic write_side(reg_type r, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_addr <= r;
      csr_wdata <= value[SIDE_W-1:0];
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      if (r <= REG_IN_Z) in_sides[r] = value[SIDE_W-1:0];
      else out_sides[r - REG_OUT_X] = value[SIDE_W-1:0];
   endtask

   task automatic set_grids(int ix, int iy, int iz, int ox, int oy, int oz);
      write_side(REG_IN_X, ix);
      write_side(REG_IN_Y, iy);
      write_side(REG_IN_Z, iz);
      write_side(REG_OUT_X, ox);
      write_side(REG_OUT_Y, oy);
      write_side(REG_OUT_Z, oz);
   endtask

   task automatic send_id(logic bwd, logic [ID_W-1:0] id);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_tvalid <= 1'b1;
      req_tuser <= bwd;
      req_tdata <= {{(DATA_W-ID_W){1'b0}}, id};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      pending_maps = {pending_maps, predict_map(bwd, id)};
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_maps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_random(int n, int lim);
      logic [ID_W-1:0] id;
      for (int i = 0; i < n; i++) begin
         id = ($urandom_range(9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(lim));
         send_id(1'($urandom_range(1)), id);
      end
   endtask

   row_type rows [] = '{
      '{1'b0, 30'd0, 1'b1, 30'd0, ST_OK},
      '{1'b1, 30'd0, 1'b1, 30'd0, ST_OK},
      '{1'b0, 30'd1, 1'b1, 30'd0, ST_ID_RANGE},
      '{1'b1, ID_MAX, 1'b1, 30'd0, ST_ID_RANGE}
   };
   row_type big_rows [] = '{
      '{1'b0, 30'd0, 1'b0, 30'd0, ST_OK},
      '{1'b0, 30'd1073741823, 1'b1, 30'd7, ST_OK},
      '{1'b1, 30'd0, 1'b0, 30'd0, ST_OK},
      '{1'b1, 30'd7, 1'b1, 30'h300c0300, ST_OK},
      '{1'b0, 30'd12345678, 1'b0, 30'd0, ST_OK},
      '{1'b1, 30'd5, 1'b0, 30'd0, ST_OK},
      '{1'b1, 30'd8, 1'b1, 30'd0, ST_ID_RANGE}
   };

   task automatic walk_rows(row_type t []);
      map_type m;
      foreach (t[i]) begin
         send_id(t[i].bwd, t[i].id);
         if (t[i].fixed) begin
            m.id = t[i].exp_id;
            m.st = t[i].exp_st;
            pending_maps[pending_maps.size()-1] = m;
         end
      end
   endtask

   initial begin
      for (int d = 0; d < 3; d++) begin
         in_sides[d] = 1;
         out_sides[d] = 1;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // directed: reset grids, then full 1024 cube onto 2x2x2
      walk_rows(rows);
      drain();
      set_grids(1024, 1024, 1024, 2, 2, 2);
      walk_rows(big_rows);
      drain();
      set_grids(1, 2, 3, 2, 2, 2);
      send_id(1'b0, 30'd0);
      send_id(1'b1, 30'd0);
      drain();
      set_grids(4, 4, 4, 0, 1, 1);
      send_id(1'b0, 30'd3);
      drain();
      set_grids(0, 1, 1, 1, 1, 1);
      send_id(1'b1, 30'd0);
      drain();
      // result out of range: forward with ratio 2 on side 5
      set_grids(5, 1, 1, 2, 1, 1);
      send_id(1'b0, 30'd4);
      drain();
      set_grids(2047, 2047, 2047, 1, 1, 1);
      send_id(1'b1, 30'd0);
      send_id(1'b0, ID_MAX);
      drain();
      set_grids(1000, 1, 1, 1, 1, 1);
      send_id(1'b0, 30'd999);
      drain();
      // random phases with idling profiles
      for (int ph = 0; ph < 8; ph++) begin
         int ix, iy, iz, ox, oy, oz;
         case (ph % 4)
            0: begin send_idle = 0; recv_stall = 0; end
            1: begin send_idle = 54; recv_stall = 0; end
            2: begin send_idle = 0; recv_stall = 54; end
            default: begin send_idle = 38; recv_stall = 38; end
         endcase
         ox = $urandom_range(1, 12);
         oy = $urandom_range(1, 12);
         oz = $urandom_range(1, 12);
         ix = ox * $urandom_range(1, 7) + $urandom_range(0, ox - 1);
         iy = oy * $urandom_range(1, 7) + $urandom_range(0, oy - 1);
         iz = oz * $urandom_range(1, 7) + $urandom_range(0, oz - 1);
         if (ph == 7) ix = $urandom_range(0, 4);
         if (ph == 6) oz = $urandom_range(0, 2047);
         set_grids(ix, iy, iz, ox, oy, oz);
         send_random(115, ix * iy * iz + 3);
         if (ph == 3) drain();
         drain();
      end
      send_idle = 0;
      recv_stall = 0;
      drain();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

### grid_id_rescale_transform.f
rtl/core/grt_pkg.sv
rtl/core/grt_div.sv
rtl/core/grt_delay.sv
rtl/core/grt_encode.sv
rtl/core/grid_id_rescale_transform.sv
tb/tb.sv
